/* rtl/order_points_by_distance_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for order_points_by_distance
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDER_POINTS_BY_DISTANCE_ASSERT_SVH
`define ORDER_POINTS_BY_DISTANCE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OPBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OPBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/opbd_pkg.sv */
// ----------------------------------------------------------------------------
// opbd_pkg
// Constants and types shared by the point ordering block.
// ----------------------------------------------------------------------------
package opbd_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 24;

  localparam int IDX_W  = 6;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 3;
  localparam int KEY_W  = DIST_W + 1;

  localparam logic ACT_TARGET = 1'b0;
  localparam logic ACT_POINT  = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_DRAIN
  } state_t;

  // Control carried alongside a beat through the distance pipeline.
  typedef struct packed {
    logic             ins;
    logic             clr;
    logic             last;
    logic             present;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic shift;
    logic ins;
  } cell_ctl_t;

endpackage

/* rtl/opbd_dist.sv */
// ----------------------------------------------------------------------------
// opbd_dist
// Three-stage squared distance pipeline: differences, squares, sum and key.
// ----------------------------------------------------------------------------
module opbd_dist (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc,
  input  logic                                   action,
  input  opbd_pkg::tag_t                         tag_in,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] coord_z,
  output logic                                   vld_o,
  output opbd_pkg::tag_t                         tag_o,
  output logic [opbd_pkg::KEY_W-1:0]             key_o
);

  logic signed [opbd_pkg::COORD_BITS-1:0] tx_r, ty_r, tz_r;
  logic signed [opbd_pkg::COORD_BITS-1:0] tx_nxt, ty_nxt, tz_nxt;

  logic                                 v1_r, v2_r, v3_r;
  opbd_pkg::tag_t                       t1_r, t2_r, t3_r;
  logic signed [opbd_pkg::DIFF_W-1:0]   dx_r, dy_r, dz_r;
  logic signed [opbd_pkg::DIFF_W-1:0]   dx_nxt, dy_nxt, dz_nxt;
  logic signed [2*opbd_pkg::DIFF_W-1:0] px, py, pz;
  logic [opbd_pkg::SQ_W-1:0]            sx_r, sy_r, sz_r;
  logic [opbd_pkg::DIST_W-1:0]          sum;
  logic [opbd_pkg::KEY_W-1:0]           key_r, key_nxt;

  always_comb begin
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    tz_nxt = tz_r;
    if (acc && action == opbd_pkg::ACT_TARGET) begin
      tx_nxt = coord_x;
      ty_nxt = coord_y;
      tz_nxt = coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      tz_r <= '0;
    end else begin
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      tz_r <= tz_nxt;
    end
  end

  // Differences are one bit wider than the coordinates, so they are exact.
  assign dx_nxt = opbd_pkg::DIFF_W'(coord_x) - opbd_pkg::DIFF_W'(tx_r);
  assign dy_nxt = opbd_pkg::DIFF_W'(coord_y) - opbd_pkg::DIFF_W'(ty_r);
  assign dz_nxt = opbd_pkg::DIFF_W'(coord_z) - opbd_pkg::DIFF_W'(tz_r);

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  assign sum = opbd_pkg::DIST_W'(sx_r) + opbd_pkg::DIST_W'(sy_r)
             + opbd_pkg::DIST_W'(sz_r);

  // Absent points sort behind every present one through the top key bit.
  assign key_nxt = t2_r.present ? {1'b0, sum} : {1'b1, {opbd_pkg::DIST_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r  <= tag_in;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    t2_r  <= t1_r;
    sx_r  <= px[opbd_pkg::SQ_W-1:0];
    sy_r  <= py[opbd_pkg::SQ_W-1:0];
    sz_r  <= pz[opbd_pkg::SQ_W-1:0];
    t3_r  <= t2_r;
    key_r <= key_nxt;
  end

  assign vld_o = v3_r;
  assign tag_o = t3_r;
  assign key_o = key_r;

endmodule

/* rtl/opbd_cell.sv */
// ----------------------------------------------------------------------------
// opbd_cell
// One slot of the insertion-sort chain: clears, keeps, takes the new entry, or
// takes a neighbor's entry.
// ----------------------------------------------------------------------------
module opbd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  opbd_pkg::cell_ctl_t ctl,
  input  opbd_pkg::entry_t   new_ent,
  input  logic               keep_prev,
  input  logic               left_vld,
  input  opbd_pkg::entry_t   left_ent,
  input  logic               right_vld,
  input  opbd_pkg::entry_t   right_ent,
  output logic               vld,
  output opbd_pkg::entry_t   ent,
  output logic               keep
);

  logic             vld_r, vld_nxt;
  opbd_pkg::entry_t ent_r, ent_nxt;

  // An equal key stays ahead, so ties keep load order.
  assign keep = vld_r && (ent_r.key <= new_ent.key);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    priority if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      vld_nxt = right_vld;
      ent_nxt = right_ent;
    end else if (ctl.ins && !keep) begin
      if (keep_prev) begin
        vld_nxt = 1'b1;
        ent_nxt = new_ent;
      end else begin
        vld_nxt = left_vld;
        ent_nxt = left_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign vld = vld_r;
  assign ent = ent_r;

endmodule

/* rtl/order_points_by_distance.sv */
// ----------------------------------------------------------------------------
// order_points_by_distance
// Ranks a set of 3-D points by squared distance to a target with an
// insertion-sort chain of cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_ready   action, coord_x/y/z, present, last_point
//  out_     output     out_valid / out_ready point_index, is_none, last_of_run
//
// While a set loads, one beat is taken per cycle; each point passes a
// three-stage distance pipeline and is then inserted into the chain.
// After the beat with last_point the input stalls until the last insertion
// is done and one result beat per loaded slot is shifted out of cell 0.
// A stall on out_ready holds the chain. Reset clears the target, the slot
// count and every cell valid bit.
module order_points_by_distance (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [opbd_pkg::COORD_BITS-1:0] in_coord_z,
  input  logic                                   in_present,
  input  logic                                   in_last_point,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [opbd_pkg::IDX_W-1:0]             out_point_index,
  output logic                                   out_is_none,
  output logic                                   out_last_of_run
);

  localparam int N = opbd_pkg::MAX_POINTS;

  opbd_pkg::state_t               state_r, state_nxt;
  logic [opbd_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                           in_acc, out_acc, room;
  opbd_pkg::tag_t                 tag_in, tag_s3;
  logic                           vld_s3;
  logic [opbd_pkg::KEY_W-1:0]     key_s3;
  opbd_pkg::cell_ctl_t            ctl;
  opbd_pkg::entry_t               new_ent;

  logic             vld  [N];
  logic             keep [N];
  opbd_pkg::entry_t ent  [N];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign room    = count_r < opbd_pkg::CNT_W'(N);

  assign tag_in.ins     = (in_action == opbd_pkg::ACT_POINT) && room;
  assign tag_in.clr     = (in_action == opbd_pkg::ACT_TARGET);
  assign tag_in.last    = (in_action == opbd_pkg::ACT_POINT) && in_last_point;
  assign tag_in.present = in_present;
  assign tag_in.idx     = opbd_pkg::IDX_W'(count_r);

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      if (tag_in.clr || tag_in.last) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      state_r <= opbd_pkg::ST_LOAD;
    end else begin
      count_r <= count_nxt;
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      opbd_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_acc && tag_in.last) begin
          state_nxt = opbd_pkg::ST_WAIT;
        end
      end
      opbd_pkg::ST_WAIT: begin
        if (vld_s3 && tag_s3.last) begin
          state_nxt = opbd_pkg::ST_DRAIN;
        end
      end
      opbd_pkg::ST_DRAIN: begin
        out_valid = vld[0];
        if (out_acc && !vld[1]) begin
          state_nxt = opbd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = opbd_pkg::ST_LOAD;
      end
    endcase
  end

  opbd_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .action  (in_action),
    .tag_in  (tag_in),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .vld_o   (vld_s3),
    .tag_o   (tag_s3),
    .key_o   (key_s3)
  );

  assign ctl.clr   = vld_s3 && tag_s3.clr;
  assign ctl.ins   = vld_s3 && tag_s3.ins;
  assign ctl.shift = out_acc;
  assign new_ent.key = key_s3;
  assign new_ent.idx = tag_s3.idx;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             kp, lv, rv;
    opbd_pkg::entry_t le, re;

    if (i == 0) begin : g_head
      assign kp = 1'b1;
      assign lv = 1'b0;
      assign le = '0;
    end else begin : g_body
      assign kp = keep[i-1];
      assign lv = vld[i-1];
      assign le = ent[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_inner
      assign rv = vld[i+1];
      assign re = ent[i+1];
    end

    opbd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .keep_prev (kp),
      .left_vld  (lv),
      .left_ent  (le),
      .right_vld (rv),
      .right_ent (re),
      .vld       (vld[i]),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  assign out_is_none     = ent[0].key[opbd_pkg::KEY_W-1];
  assign out_point_index = out_is_none ? '0 : ent[0].idx;
  assign out_last_of_run = !vld[1];

endmodule

/* rtl/opbd_checker.sv */
// ----------------------------------------------------------------------------
// opbd_checker
// Port-level checks on the point ordering block, bound to its top level.
// ----------------------------------------------------------------------------
`include "order_points_by_distance_assert.svh"

module opbd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_action,
  input logic                       in_last_point,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [opbd_pkg::IDX_W-1:0] out_point_index,
  input logic                       out_is_none,
  input logic                       out_last_of_run
);

  // A result beat that is held back keeps its payload.
  `OPBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_point_index) && $stable(out_is_none) && $stable(out_last_of_run), "stalled result beat changed")

  // No new input is taken while ranked results are going out.
  `OPBD_ASSERT_NOW(a_no_in_during_out, out_valid, !in_ready, "input ready while emitting results")

  `OPBD_ASSERT_NOW(a_none_index, out_valid && out_is_none, out_point_index == '0, "none result with nonzero index")

  // The beat that closes a set stops the input until the ranking is out.
  `OPBD_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && (in_action == opbd_pkg::ACT_POINT) && in_last_point, !in_ready, "input ready right after last point")

  `OPBD_ASSERT_NEXT(a_run_ends, out_valid && out_ready && out_last_of_run, !out_valid, "result beat after end of run")

endmodule

bind order_points_by_distance opbd_checker u_opbd_checker (.*);

/* sim/order_points_by_distance_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_points_by_distance_tb
// Streams target and point beats into the point ordering block and checks
// every ranked result against a local ranking of exact squared distances.
// Both handshakes idle at random; the result side holds off once for a long
// stretch and the sender waits for the block to drain before each target beat marked drain_first.
// ----------------------------------------------------------------------------
module order_points_by_distance_tb;

  typedef logic signed [opbd_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   action;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   present;
    logic   last;
    logic   drain_first;
  } point_beat_t;

  typedef struct {
    logic [opbd_pkg::IDX_W-1:0] idx;
    logic                       is_none;
    logic                       last;
  } rank_entry_t;

  localparam coord_t COORD_MAX   = {1'b0, {(opbd_pkg::COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN   = {1'b1, {(opbd_pkg::COORD_BITS-1){1'b0}}};
  localparam int     ITEM_GOAL   = 180;
  localparam int     LIMIT_CYC   = 200000;
  localparam int     LONG_HOLD   = 400;
  localparam int     SETTLE_CYC  = 20;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_action = opbd_pkg::ACT_TARGET;
  coord_t                     in_coord_x = '0;
  coord_t                     in_coord_y = '0;
  coord_t                     in_coord_z = '0;
  logic                       in_present = 1'b0;
  logic                       in_last_point = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [opbd_pkg::IDX_W-1:0] out_point_index;
  logic                       out_is_none;
  logic                       out_last_of_run;

  point_beat_t point_beats_q[$];
  rank_entry_t rank_due[$];

  // Local copy of the block's state, updated on every accepted input beat.
  coord_t  tgt_x = '0;
  coord_t  tgt_y = '0;
  coord_t  tgt_z = '0;
  longint  slot_dist[opbd_pkg::MAX_POINTS];
  bit      slot_present[opbd_pkg::MAX_POINTS];
  int      slots_loaded = 0;

  int      mismatches = 0;
  int      results_seen = 0;
  int      cycle_count = 0;
  logic    in_taken = 1'b0;
  int      in_gap_left = 0;
  int      in_burst_left = 0;
  int      out_burst_left = 0;
  int      ready_gap_left = 0;
  int      hold_left = 0;
  bit      long_hold_done = 1'b0;
  int      items_queued = 0;
  coord_t  gen_tx = '0;
  coord_t  gen_ty = '0;
  coord_t  gen_tz = '0;
  coord_t  prev_x = '0;
  coord_t  prev_y = '0;
  coord_t  prev_z = '0;
  longint  dx;
  longint  dy;
  longint  dz;
  point_beat_t next_beat;
  rank_entry_t rank_want;

  order_points_by_distance i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_present      (in_present),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_index (out_point_index),
    .out_is_none     (out_is_none),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a burst with none.
  function automatic int idle_len(bit rx_side);
    int roll;
    roll = $urandom_range(0, 99);
    if (rx_side ? out_burst_left > 0 : in_burst_left > 0) begin
      if (rx_side) out_burst_left--;
      else in_burst_left--;
      return 0;
    end
    if (roll < 4) begin
      if (rx_side) out_burst_left = $urandom_range(20, 60);
      else in_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic queue_beat(logic action, coord_t x, coord_t y, coord_t z,
                            logic present, logic last, logic drain_first);
    point_beat_t b;
    b.action      = action;
    b.x           = x;
    b.y           = y;
    b.z           = z;
    b.present     = present;
    b.last        = last;
    b.drain_first = drain_first;
    point_beats_q.push_back(b);
    items_queued++;
    if (action == opbd_pkg::ACT_TARGET) begin
      gen_tx = x;
      gen_ty = y;
      gen_tz = z;
    end else begin
      prev_x = x;
      prev_y = y;
      prev_z = z;
    end
  endtask

  // Selection over the loaded slots: nearest present point first, the
  // earlier slot winning a tie, then one none entry per absent slot.
  task automatic rank_loaded_points();
    bit          picked[opbd_pkg::MAX_POINTS];
    int          best;
    int          emitted;
    rank_entry_t e;
    emitted = 0;
    foreach (picked[i]) picked[i] = 1'b0;
    do begin
      best = -1;
      for (int i = 0; i < slots_loaded; i++) begin
        if (slot_present[i] && !picked[i] &&
            (best < 0 || slot_dist[i] < slot_dist[best])) best = i;
      end
      if (best >= 0) begin
        picked[best] = 1'b1;
        e.idx     = opbd_pkg::IDX_W'(best);
        e.is_none = 1'b0;
        e.last    = (emitted == slots_loaded - 1);
        rank_due.push_back(e);
        emitted++;
      end
    end while (best >= 0);
    while (emitted < slots_loaded) begin
      e.idx     = '0;
      e.is_none = 1'b1;
      e.last    = (emitted == slots_loaded - 1);
      rank_due.push_back(e);
      emitted++;
    end
    slots_loaded = 0;
  endtask

  // Input beats are taken and results checked at the rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready && rst_n;
    if (rst_n && in_valid && in_ready) begin
      if (in_action == opbd_pkg::ACT_TARGET) begin
        tgt_x = in_coord_x;
        tgt_y = in_coord_y;
        tgt_z = in_coord_z;
        slots_loaded = 0;
      end else begin
        // A point beat arriving on a full set is dropped.
        if (slots_loaded < opbd_pkg::MAX_POINTS) begin
          dx = longint'(in_coord_x) - longint'(tgt_x);
          dy = longint'(in_coord_y) - longint'(tgt_y);
          dz = longint'(in_coord_z) - longint'(tgt_z);
          slot_dist[slots_loaded]    = in_present ? dx * dx + dy * dy + dz * dz : 0;
          slot_present[slots_loaded] = in_present;
          slots_loaded++;
        end
        if (in_last_point) rank_loaded_points();
      end
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (rank_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: index %0d none %0b last %0b",
                 $time, out_point_index, out_is_none, out_last_of_run);
      end else begin
        rank_want = rank_due.pop_front();
        if (out_point_index !== rank_want.idx) begin
          mismatches++;
          $display("%0t: point_index expected %0d actual %0d",
                   $time, rank_want.idx, out_point_index);
        end
        if (out_is_none !== rank_want.is_none) begin
          mismatches++;
          $display("%0t: is_none expected %0b actual %0b",
                   $time, rank_want.is_none, out_is_none);
        end
        if (out_last_of_run !== rank_want.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, rank_want.last, out_last_of_run);
        end
      end
    end
  end

  // Sender: holds a beat until it is taken, then idles for a random gap.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left--;
      end else if (point_beats_q.size() > 0 &&
                   !(point_beats_q[0].drain_first && rank_due.size() > 0)) begin
        next_beat = point_beats_q.pop_front();
        in_valid      <= 1'b1;
        in_action     <= next_beat.action;
        in_coord_x    <= next_beat.x;
        in_coord_y    <= next_beat.y;
        in_coord_z    <= next_beat.z;
        in_present    <= next_beat.present;
        in_last_point <= next_beat.last;
        in_gap_left = idle_len(1'b0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold while results are waiting.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && out_valid && results_seen >= 40) begin
        out_ready <= 1'b0;
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (ready_gap_left > 0) begin
        out_ready <= 1'b0;
        ready_gap_left--;
      end else begin
        out_ready <= 1'b1;
        ready_gap_left = idle_len(1'b1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("order_points_by_distance verification failed");
      $finish;
    end
  end

  initial begin
    int     n;
    int     mode;
    bit     first_big;
    bit     aborted;
    coord_t px;
    coord_t py;
    coord_t pz;

    // Points before any target are measured against the zero target.
    queue_beat(opbd_pkg::ACT_POINT, 24'sd100, -24'sd200, 24'sd300, 1'b1, 1'b1, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), 1'b0, 1'b1, 1'b0);
    // Target at the top corner; its present and last flags must be ignored.
    queue_beat(opbd_pkg::ACT_TARGET, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), 1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MAX - coord_t'(1), COORD_MAX, COORD_MAX,
               1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MAX, COORD_MAX - coord_t'(1), COORD_MAX,
               1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX - coord_t'(1),
               1'b1, 1'b1, 1'b0);
    // A second target in the middle of a set throws the loaded points away.
    queue_beat(opbd_pkg::ACT_TARGET, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_TARGET, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, -24'sd1, 24'sd1, '0, 1'b1, 1'b1, 1'b0);
    // New set against the same target, with a tie on distance.
    queue_beat(opbd_pkg::ACT_POINT, 24'sd1, 24'sd1, 24'sd1, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, -24'sd1, -24'sd1, -24'sd1, 1'b1, 1'b1, 1'b0);
    queue_beat(opbd_pkg::ACT_TARGET, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
               1'b0, 1'b0, 1'b1);
    queue_beat(opbd_pkg::ACT_POINT, 24'h555555, 24'hAAAAAA, 24'h555555,
               1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, 24'h555555, 24'hAAAAAA, 24'h555555,
               1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, '0, '0, '0, 1'b0, 1'b1, 1'b0);
    queue_beat(opbd_pkg::ACT_TARGET, '0, '0, '0, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, '0, '0, 24'sd1, 1'b1, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    queue_beat(opbd_pkg::ACT_POINT, '0, '0, -24'sd1, 1'b1, 1'b1, 1'b0);

    // Random sets. The first large one overruns the chain, with last_point on
    // a beat that is itself dropped.
    first_big = 1'b1;
    while (items_queued < ITEM_GOAL) begin
      if (first_big) n = opbd_pkg::MAX_POINTS + 2;
      else if ($urandom_range(0, 99) < 8)
        n = $urandom_range(opbd_pkg::MAX_POINTS - 2, opbd_pkg::MAX_POINTS + 3);
      else n = $urandom_range(1, 6);
      if ($urandom_range(0, 7) != 0)
        queue_beat(opbd_pkg::ACT_TARGET, coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), 1'($urandom), 1'($urandom),
                   $urandom_range(0, 9) == 0);
      aborted = !first_big && ($urandom_range(0, 9) == 0);
      first_big = 1'b0;
      for (int k = 0; k < n; k++) begin
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          px = coord_t'($urandom);
          py = coord_t'($urandom);
          pz = coord_t'($urandom);
        end else if (mode < 8) begin
          px = gen_tx + coord_t'($urandom_range(0, 8)) - coord_t'(4);
          py = gen_ty + coord_t'($urandom_range(0, 8)) - coord_t'(4);
          pz = gen_tz + coord_t'($urandom_range(0, 8)) - coord_t'(4);
        end else begin
          px = prev_x;
          py = prev_y;
          pz = prev_z;
        end
        queue_beat(opbd_pkg::ACT_POINT, px, py, pz, $urandom_range(0, 5) != 0,
                   (k == n - 1) && !aborted, 1'b0);
      end
      if ($urandom_range(0, 9) == 0)
        queue_beat(opbd_pkg::ACT_TARGET, coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), 1'($urandom), 1'($urandom), 1'b0);
    end
    // Close whatever set is still open.
    queue_beat(opbd_pkg::ACT_POINT, coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), 1'b1, 1'b1, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (point_beats_q.size() != 0 || in_valid) @(posedge clk);
    while (rank_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("order_points_by_distance verification clean");
    end else begin
      $display("order_points_by_distance verification failed");
    end
    $finish;
  end

endmodule
